### design/knn_pkg.sv
// Shared types and constants for the 2-D k-nearest-neighbour classifier.
// Used by knn_binary_classifier_2d_unit and its testbench; depends on nothing.
package knn_pkg;

  localparam logic [1:0] CMD_APPEND   = 2'd0;
  localparam logic [1:0] CMD_CLASSIFY = 2'd1;
  localparam logic [1:0] CMD_CLEAR    = 2'd2;

  localparam int CoordW = 16;
  localparam int LabelW = 2;
  localparam int VoteW  = 5;
  localparam int MagW   = CoordW;
  localparam int SqW    = 2 * MagW;
  localparam int DistW  = SqW + 1;

  localparam logic [LabelW-1:0] LABEL_ZERO = 2'd0;
  localparam logic [LabelW-1:0] LABEL_ONE  = 2'd1;

  typedef struct packed {
    logic [1:0]               command;
    logic [LabelW-1:0]        label;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
  } cmd_word_t;

  typedef struct packed {
    logic             predicted_class;
    logic [VoteW-1:0] votes_zero;
    logic [VoteW-1:0] votes_one;
  } res_word_t;

  typedef struct packed {
    logic [LabelW-1:0]        label;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
  } point_t;

  localparam int PointW = $bits(point_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEXT,
    ST_SUBX,
    ST_MULX,
    ST_MULY,
    ST_ADD,
    ST_CHECK,
    ST_INS,
    ST_VOTE,
    ST_DONE
  } state_t;

endpackage

### design/knn_binary_classifier_2d_unit.sv
// k-nearest-neighbour classifier over signed Q8.8 2-D points; uses knn_pkg, knn_ram.
// Append, clear and unused commands are handled in the idle state and give no result word.
// Classify scans the N stored points and then votes over the best list: each point passes once
// through the one subtract/multiply unit, then, unless a full list drops it, walks the best list
// one entry a cycle.
// One command at a time; a result word waits in the output register while the next is taken.
// Synchronous reset empties the store and sets k to 1; store contents are not cleared.
module knn_binary_classifier_2d_unit #(
  parameter int MAX_POINTS = 64,
  parameter int K_MAX      = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  knn_pkg::cmd_word_t    cmd_word,
  output logic                  res_valid,
  input  logic                  res_ready,
  output knn_pkg::res_word_t    res_word,
  input  logic                  cfg_wr_en,
  input  logic [4:0]            cfg_wr_data
);

  localparam int CntW  = $clog2(MAX_POINTS + 1);
  localparam int AddrW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int KW    = $clog2(K_MAX + 1);
  localparam int IdxW  = (K_MAX > 1) ? $clog2(K_MAX) : 1;

  knn_pkg::state_t state, state_next;

  logic [CntW-1:0]                    count;
  logic [CntW-1:0]                    pt_idx;
  logic [4:0]                         k_reg;
  logic [KW-1:0]                      keff;
  logic [KW-1:0]                      filled;
  logic [KW-1:0]                      j;
  logic [KW-1:0]                      v0;
  logic [KW-1:0]                      v1;
  logic signed [knn_pkg::CoordW-1:0]  qx;
  logic signed [knn_pkg::CoordW-1:0]  qy;
  logic [knn_pkg::MagW-1:0]           opnd;
  logic [knn_pkg::SqW-1:0]            prod;
  logic [knn_pkg::SqW-1:0]            acc;
  logic [knn_pkg::DistW-1:0]          cur_dist;

  logic [knn_pkg::DistW-1:0]          best_dist [K_MAX];
  logic [knn_pkg::LabelW-1:0]         best_lab  [K_MAX];

  logic                               accept;
  logic                               full;
  logic                               ram_we;
  logic                               ram_re;
  knn_pkg::point_t                    ram_wdata;
  logic [knn_pkg::PointW-1:0]         ram_rword;
  knn_pkg::point_t                    pt;
  logic [IdxW-1:0]                    rd_idx;
  logic                               gt;
  logic [31:0]                        k_clamp;
  logic [4:0]                         k_nz;
  logic [KW-1:0]                      last;

  function automatic logic [knn_pkg::MagW-1:0] abs_diff(
    input logic signed [knn_pkg::CoordW-1:0] a,
    input logic signed [knn_pkg::CoordW-1:0] b
  );
    logic signed [knn_pkg::CoordW:0] d;
    d = {a[knn_pkg::CoordW-1], a} - {b[knn_pkg::CoordW-1], b};
    return d[knn_pkg::CoordW] ? knn_pkg::MagW'(-d) : d[knn_pkg::MagW-1:0];
  endfunction

  assign accept = cmd_valid && cmd_ready;
  assign full   = (count == CntW'(MAX_POINTS));
  assign pt     = knn_pkg::point_t'(ram_rword);
  assign gt     = (best_dist[rd_idx] > cur_dist);
  assign last   = (filled < keff) ? filled : keff - KW'(1);

  assign ram_wdata.label = cmd_word.label;
  assign ram_wdata.x     = cmd_word.coord_x;
  assign ram_wdata.y     = cmd_word.coord_y;

  knn_ram #(
    .Width (knn_pkg::PointW),
    .Depth (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AddrW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (pt_idx[AddrW-1:0]),
    .rdata (ram_rword)
  );

  // effective k: zero reads as one, then saturate to the list size and the store fill
  always_comb begin
    k_nz    = (k_reg == 5'd0) ? 5'd1 : k_reg;
    k_clamp = 32'(k_nz);
    if (k_clamp > 32'(K_MAX)) begin
      k_clamp = 32'(K_MAX);
    end
    if (k_clamp > 32'(count)) begin
      k_clamp = 32'(count);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      knn_pkg::ST_IDLE: begin
        if (accept && cmd_word.command == knn_pkg::CMD_CLASSIFY) begin
          state_next = knn_pkg::ST_NEXT;
        end
      end
      knn_pkg::ST_NEXT: begin
        state_next = (pt_idx == count) ? knn_pkg::ST_VOTE : knn_pkg::ST_SUBX;
      end
      knn_pkg::ST_SUBX:  state_next = knn_pkg::ST_MULX;
      knn_pkg::ST_MULX:  state_next = knn_pkg::ST_MULY;
      knn_pkg::ST_MULY:  state_next = knn_pkg::ST_ADD;
      knn_pkg::ST_ADD: begin
        state_next = (filled == keff) ? knn_pkg::ST_CHECK : knn_pkg::ST_INS;
      end
      knn_pkg::ST_CHECK: begin
        state_next = gt ? knn_pkg::ST_INS : knn_pkg::ST_NEXT;
      end
      knn_pkg::ST_INS: begin
        if (!(j != '0 && gt)) begin
          state_next = knn_pkg::ST_NEXT;
        end
      end
      knn_pkg::ST_VOTE: begin
        if (j == filled) begin
          state_next = knn_pkg::ST_DONE;
        end
      end
      knn_pkg::ST_DONE: begin
        if (!res_valid || res_ready) begin
          state_next = knn_pkg::ST_IDLE;
        end
      end
      default: state_next = knn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    rd_idx    = j[IdxW-1:0];
    unique case (state)
      knn_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        ram_we    = cmd_valid && cmd_word.command == knn_pkg::CMD_APPEND && !full;
      end
      knn_pkg::ST_NEXT: ram_re = (pt_idx != count);
      // compare against the entry just above the hole
      knn_pkg::ST_INS:  rd_idx = IdxW'(j - KW'(1));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= knn_pkg::ST_IDLE;
      count  <= '0;
      k_reg  <= 5'd1;
      keff   <= '0;
      filled <= '0;
      pt_idx <= '0;
      j      <= '0;
      v0     <= '0;
      v1     <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        k_reg <= cfg_wr_data;
      end
      unique case (state)
        knn_pkg::ST_IDLE: begin
          if (accept) begin
            case (cmd_word.command)
              knn_pkg::CMD_APPEND: begin
                if (!full) begin
                  count <= count + CntW'(1);
                end
              end
              knn_pkg::CMD_CLEAR: count <= '0;
              knn_pkg::CMD_CLASSIFY: begin
                qx     <= cmd_word.coord_x;
                qy     <= cmd_word.coord_y;
                pt_idx <= '0;
                filled <= '0;
                keff   <= KW'(k_clamp);
              end
              default: ;
            endcase
          end
        end
        knn_pkg::ST_NEXT: begin
          if (pt_idx == count) begin
            j  <= '0;
            v0 <= '0;
            v1 <= '0;
          end
        end
        knn_pkg::ST_SUBX: opnd <= abs_diff(pt.x, qx);
        knn_pkg::ST_MULX: begin
          prod <= opnd * opnd;
          opnd <= abs_diff(pt.y, qy);
        end
        knn_pkg::ST_MULY: begin
          prod <= opnd * opnd;
          acc  <= prod;
        end
        knn_pkg::ST_ADD: begin
          cur_dist <= knn_pkg::DistW'(acc) + knn_pkg::DistW'(prod);
          j        <= last;
        end
        knn_pkg::ST_CHECK: begin
          // no closer than the worst of a full list: drop the point
          if (!gt) begin
            pt_idx <= pt_idx + CntW'(1);
          end
        end
        knn_pkg::ST_INS: begin
          if (j != '0 && gt) begin
            best_dist[j[IdxW-1:0]] <= best_dist[rd_idx];
            best_lab[j[IdxW-1:0]]  <= best_lab[rd_idx];
            j <= j - KW'(1);
          end else begin
            best_dist[j[IdxW-1:0]] <= cur_dist;
            best_lab[j[IdxW-1:0]]  <= pt.label;
            if (filled < keff) begin
              filled <= filled + KW'(1);
            end
            pt_idx <= pt_idx + CntW'(1);
          end
        end
        knn_pkg::ST_VOTE: begin
          if (j != filled) begin
            if (best_lab[rd_idx] == knn_pkg::LABEL_ZERO) begin
              v0 <= v0 + KW'(1);
            end else if (best_lab[rd_idx] == knn_pkg::LABEL_ONE) begin
              v1 <= v1 + KW'(1);
            end
            j <= j + KW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // output word register: drop when taken, load when the vote is done
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == knn_pkg::ST_DONE && (!res_valid || res_ready)) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == knn_pkg::ST_DONE && (!res_valid || res_ready)) begin
      res_word.predicted_class <= !(v0 > v1);
      res_word.votes_zero      <= knn_pkg::VoteW'(v0);
      res_word.votes_one       <= knn_pkg::VoteW'(v1);
    end
  end

  a_res_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == knn_pkg::ST_DONE)
    else $error("result word raised outside the done state");

  a_filled_le_k: assert property (@(posedge clk) disable iff (rst)
    filled <= keff)
    else $error("best list holds more entries than k");

  a_votes_le_filled: assert property (@(posedge clk) disable iff (rst)
    state == knn_pkg::ST_VOTE |-> (KW + 1)'(v0) + (KW + 1)'(v1) <= (KW + 1)'(j))
    else $error("vote counters exceed entries counted");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state != knn_pkg::ST_IDLE |-> pt_idx <= count)
    else $error("scan index ran past the stored count");

  a_keff_le_count: assert property (@(posedge clk) disable iff (rst)
    state == knn_pkg::ST_ADD |-> keff != '0 && CntW'(keff) <= count)
    else $error("effective k out of range during scan");

endmodule

### design/knn_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package needed.
module knn_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AddrW-1:0]       waddr,
  input  logic [Width-1:0]       wdata,
  input  logic                   re,
  input  logic [AddrW-1:0]       raddr,
  output logic [Width-1:0]       rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold the last read word until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### test/knn_binary_classifier_2d_unit_tb.sv
// Self-checking testbench for knn_binary_classifier_2d_unit: drives command words, predicts
// each classify result from its own copy of the point store and checks every result word.
// Depends on knn_pkg and the design files; needs nothing else.
module knn_binary_classifier_2d_unit_tb;

  localparam int STORE_DEPTH = 64;
  localparam int K_LIMIT = 16;
  localparam int TARGET_WORDS = 1300;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES = 2000;
  localparam longint CYCLE_LIMIT = 64'd10_000_000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum int {COORD_ANY, COORD_GRID, COORD_EDGE} coord_mode_t;

  // Expected classify results, predicted from a private copy of the store and of k.
  class knn_scoreboard;
    logic signed [knn_pkg::CoordW-1:0] pt_x[STORE_DEPTH];
    logic signed [knn_pkg::CoordW-1:0] pt_y[STORE_DEPTH];
    logic [knn_pkg::LabelW-1:0] pt_label[STORE_DEPTH];
    int n_points;
    logic [4:0] k_setting;
    knn_pkg::res_word_t expected_q[$];
    int errors, n_append, n_dropped, n_query, n_clear, n_ignored, n_checked;

    function new();
      n_points = 0;
      k_setting = 5'd1;
      errors = 0;
      n_append = 0;
      n_dropped = 0;
      n_query = 0;
      n_clear = 0;
      n_ignored = 0;
      n_checked = 0;
    endfunction

    function void set_k(logic [4:0] value);
      k_setting = value;
    endfunction

    // Pick the k nearest points one by one; the lowest index wins among equal distances.
    function knn_pkg::res_word_t vote_nearest(logic signed [knn_pkg::CoordW-1:0] qx,
                                              logic signed [knn_pkg::CoordW-1:0] qy);
      bit taken[STORE_DEPTH];
      longint range_sq[STORE_DEPTH];
      longint dx, dy;
      int k, pick, zeros, ones;
      knn_pkg::res_word_t r;
      k = (k_setting == 0) ? 1 : int'(k_setting);
      if (k > K_LIMIT) k = K_LIMIT;
      if (k > n_points) k = n_points;
      zeros = 0;
      ones = 0;
      for (int i = 0; i < n_points; i++) begin
        dx = longint'(pt_x[i]) - longint'(qx);
        dy = longint'(pt_y[i]) - longint'(qy);
        range_sq[i] = dx * dx + dy * dy;
        taken[i] = 1'b0;
      end
      for (int rank = 0; rank < k; rank++) begin
        pick = -1;
        for (int i = 0; i < n_points; i++) begin
          if (!taken[i] && (pick < 0 || range_sq[i] < range_sq[pick])) pick = i;
        end
        taken[pick] = 1'b1;
        if (pt_label[pick] == knn_pkg::LABEL_ZERO) zeros++;
        else if (pt_label[pick] == knn_pkg::LABEL_ONE) ones++;
      end
      r.predicted_class = (zeros > ones) ? 1'b0 : 1'b1;
      r.votes_zero = knn_pkg::VoteW'(zeros);
      r.votes_one = knn_pkg::VoteW'(ones);
      return r;
    endfunction

    function void record_command(knn_pkg::cmd_word_t w);
      case (w.command)
        knn_pkg::CMD_APPEND: begin
          if (n_points < STORE_DEPTH) begin
            pt_x[n_points] = w.coord_x;
            pt_y[n_points] = w.coord_y;
            pt_label[n_points] = w.label;
            n_points++;
            n_append++;
          end else begin
            n_dropped++;
          end
        end
        knn_pkg::CMD_CLASSIFY: begin
          expected_q.push_back(vote_nearest(w.coord_x, w.coord_y));
          n_query++;
        end
        knn_pkg::CMD_CLEAR: begin
          n_points = 0;
          n_clear++;
        end
        default: n_ignored++;
      endcase
    endfunction

    function void check_result(knn_pkg::res_word_t got);
      knn_pkg::res_word_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result word %p", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (got.predicted_class !== want.predicted_class) begin
        $error("predicted_class: expected %0d, got %0d", want.predicted_class,
               got.predicted_class);
        errors++;
      end
      if (got.votes_zero !== want.votes_zero) begin
        $error("votes_zero: expected %0d, got %0d", want.votes_zero, got.votes_zero);
        errors++;
      end
      if (got.votes_one !== want.votes_one) begin
        $error("votes_one: expected %0d, got %0d", want.votes_one, got.votes_one);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  knn_pkg::cmd_word_t cmd_word = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  knn_pkg::res_word_t res_word;
  logic cfg_wr_en = 1'b0;
  logic [4:0] cfg_wr_data = '0;

  knn_scoreboard sb;
  int n_sent = 0;
  int k_writes = 0;
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  int stall_left = 0;
  longint cycles = 0;

  knn_binary_classifier_2d_unit #(
    .MAX_POINTS(STORE_DEPTH),
    .K_MAX(K_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_word(cmd_word),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_word(res_word),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("knn_binary_classifier_2d_unit_tb: FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      stall_left = HOLD_CYCLES;
      res_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_ready <= 1'b0;
    end else begin
      res_ready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) sb.check_result(res_word);
  end

  function automatic knn_pkg::cmd_word_t make_word(logic [1:0] command,
                                                   logic [knn_pkg::LabelW-1:0] label,
                                                   logic signed [knn_pkg::CoordW-1:0] x,
                                                   logic signed [knn_pkg::CoordW-1:0] y);
    knn_pkg::cmd_word_t w;
    w.command = command;
    w.label = label;
    w.coord_x = x;
    w.coord_y = y;
    return w;
  endfunction

  function automatic logic signed [knn_pkg::CoordW-1:0] pick_coord(coord_mode_t mode);
    int v;
    case (mode)
      COORD_GRID: begin
        // coarse grid: plenty of equal distances
        v = (int'($urandom_range(0, 8)) - 4) * 128;
        return v[knn_pkg::CoordW-1:0];
      end
      COORD_EDGE: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: return knn_pkg::CoordW'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [knn_pkg::LabelW-1:0] pick_label();
    if ($urandom_range(0, 9) < 8) return knn_pkg::LabelW'($urandom_range(0, 1));
    return knn_pkg::LabelW'($urandom_range(2, 3));
  endfunction

  function automatic logic [4:0] pick_k();
    case ($urandom_range(0, 7))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd16;
      3: return 5'd17;
      4: return 5'd31;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  task automatic send_word(knn_pkg::cmd_word_t w);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word <= w;
    do @(posedge clk); while (!cmd_ready);
    sb.record_command(w);
    if (w.command != CMD_UNUSED) n_sent++;
  endtask

  // Drop valid, let every pending result drain, then give appends time to retire.
  task automatic wait_idle();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_k(logic [4:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_k(value);
    k_writes++;
  endtask

  task automatic run_directed();
    send_word(make_word(knn_pkg::CMD_CLASSIFY, 2'd0, 16'sh0000, 16'sh0000));
    send_word(make_word(CMD_UNUSED, 2'd3, 16'sh1234, 16'shedcb));
    send_word(make_word(knn_pkg::CMD_APPEND, 2'd0, 16'sh8000, 16'sh8000));
    send_word(make_word(knn_pkg::CMD_APPEND, 2'd1, 16'sh7fff, 16'sh7fff));
    send_word(make_word(knn_pkg::CMD_APPEND, 2'd2, 16'sh0000, 16'sh0000));
    send_word(make_word(knn_pkg::CMD_APPEND, 2'd3, 16'sh7fff, 16'sh8000));
    // label on a query is don't-care
    send_word(make_word(knn_pkg::CMD_CLASSIFY, 2'd3, 16'sh8000, 16'sh8000));
    wait_idle();
    write_k(5'd31);
    send_word(make_word(knn_pkg::CMD_CLASSIFY, 2'd1, 16'sh7fff, 16'sh7fff));
    send_word(make_word(knn_pkg::CMD_CLEAR, 2'd0, 16'sh0000, 16'sh0000));
    // two points equally far from the origin: earlier one must rank first
    send_word(make_word(knn_pkg::CMD_APPEND, 2'd0, 16'sh0100, 16'sh0000));
    send_word(make_word(knn_pkg::CMD_APPEND, 2'd1, -16'sh0100, 16'sh0000));
    wait_idle();
    write_k(5'd1);
    send_word(make_word(knn_pkg::CMD_CLASSIFY, 2'd0, 16'sh0000, 16'sh0000));
    wait_idle();
    write_k(5'd2);
    send_word(make_word(knn_pkg::CMD_CLASSIFY, 2'd0, 16'sh0000, 16'sh0000));
    wait_idle();
    write_k(5'd0);
    send_word(make_word(knn_pkg::CMD_CLASSIFY, 2'd2, 16'sh0000, 16'sh0000));
    send_word(make_word(knn_pkg::CMD_APPEND, 2'd1, 16'sh0000, 16'sh0100));
    send_word(make_word(knn_pkg::CMD_APPEND, 2'd1, 16'sh0000, -16'sh0100));
    wait_idle();
    write_k(5'd17);
    send_word(make_word(knn_pkg::CMD_CLASSIFY, 2'd0, 16'sh0000, 16'sh0000));
    send_word(make_word(knn_pkg::CMD_CLEAR, 2'd0, 16'sh0000, 16'sh0000));
    send_word(make_word(knn_pkg::CMD_CLASSIFY, 2'd0, 16'sh0000, 16'sh0000));
  endtask

  task automatic run_round(int round_no);
    coord_mode_t mode;
    int n_points, n_queries;
    mode = coord_mode_t'($urandom_range(0, 2));
    steady = ($urandom_range(0, 4) == 0);
    if (round_no != 8 && $urandom_range(0, 3) == 0) begin
      wait_idle();
      write_k(pick_k());
    end
    if (round_no == 8) hold_req = 1'b1;
    if ($urandom_range(0, 3) != 0)
      send_word(make_word(knn_pkg::CMD_CLEAR, pick_label(), pick_coord(COORD_ANY),
                          pick_coord(COORD_ANY)));
    n_points = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 10);
    n_queries = (round_no == 8) ? 6 : $urandom_range(1, 5);
    repeat (n_points) begin
      if ($urandom_range(0, 19) == 0)
        send_word(make_word(CMD_UNUSED, pick_label(), pick_coord(COORD_ANY),
                            pick_coord(COORD_ANY)));
      if ($urandom_range(0, 4) == 0) mode = coord_mode_t'($urandom_range(0, 2));
      send_word(make_word(knn_pkg::CMD_APPEND, pick_label(), pick_coord(mode),
                          pick_coord(mode)));
    end
    repeat (n_queries) begin
      send_word(make_word(knn_pkg::CMD_CLASSIFY, knn_pkg::LabelW'($urandom_range(0, 3)),
                          pick_coord(mode), pick_coord(mode)));
    end
  endtask

  initial begin
    int round_no;
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    run_directed();
    round_no = 0;
    while (n_sent < TARGET_WORDS) begin
      run_round(round_no);
      round_no++;
    end
    steady = 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run: %0d appends (%0d refused by a full store), %0d clears, %0d classifies,",
             sb.n_append, sb.n_dropped, sb.n_clear, sb.n_query);
    $display("run: %0d ignored words, %0d result words checked across %0d writes of k",
             sb.n_ignored, sb.n_checked, k_writes);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("knn_binary_classifier_2d_unit_tb: PASS");
    end else begin
      $display("knn_binary_classifier_2d_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

### files.f
design/knn_pkg.sv
design/knn_ram.sv
design/knn_binary_classifier_2d_unit.sv
test/knn_binary_classifier_2d_unit_tb.sv
